>>> rtl/core/mer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  localparam int ORIGIN_W  = 10;
  localparam int CENTER_W  = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [ORIGIN_W-1:0]  ORIGIN_RST   = 10'd320;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'b1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [1:0] K_LAST = 2'd3;

  typedef enum logic [1:0] {
    EMIT_START,
    EMIT_STEP,
    EMIT_IDLE
  } emit_kind_t;

  typedef enum logic [2:0] {
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RX2_RY,
    MUL_RX2_RY2,
    MUL_A_A,
    MUL_B_B,
    MUL_RY2_T,
    MUL_RX2_T
  } mul_sel_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_RX2,
    WB_RY2,
    WB_START_DEC,
    WB_DEC_INIT,
    WB_TMP,
    WB_DEC_ADD,
    WB_DEC_ADD4
  } wb_sel_t;

  typedef struct packed {
    logic       load;
    mul_sel_t   mul_sel;
    wb_sel_t    wb_sel;
    logic       iter_a;
    logic       iter_b;
    logic       region2;
    logic       out_load;
    emit_kind_t kind;
    logic [1:0] k;
    logic       last;
    logic       done;
  } mer_cmd_t;

  typedef struct packed {
    logic grad_lt;
    logic y_zero;
    logic ry_zero;
  } mer_status_t;

endpackage

`default_nettype wire

>>> rtl/core/mer_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mer_in_if import mer_pkg::*; #(
  parameter int RADIUS_BITS = 9
) ();
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [CENTER_W-1:0] center_x;
  logic signed [CENTER_W-1:0] center_y;
  logic [RADIUS_BITS-1:0]     radius_x;
  logic [RADIUS_BITS-1:0]     radius_y;

  modport source (output valid, op, center_x, center_y, radius_x, radius_y, input ready);
  modport sink   (input valid, op, center_x, center_y, radius_x, radius_y, output ready);
endinterface

interface mer_out_if #(
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         pixel_valid;
  logic                         last;
  logic                         done_res;

  modport source (output valid, pixel_x, pixel_y, pixel_valid, last, done_res, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_valid, last, done_res, output ready);
endinterface

interface mer_cfg_if import mer_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ORIGIN_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/midpoint_ellipse_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Midpoint ellipse rasterizer. An op=0 request loads the centre (mapped to the
// screen as origin_x+center_x, origin_y-center_y) and the two radii and returns
// the four axis pixels; each op=1 request advances one midpoint iteration and
// returns the four symmetric pixels, with done_res set on every result once y
// reaches zero. A step while no ellipse is active returns one empty result.
// A start goes from the accept state through the shared multiplier for the
// squares and start terms (S_M1 to S_M4) to its four results; a step goes
// through accept, the iteration states S_IT_A and S_IT_B and four results,
// and a step crossing into region two first forms the products of its new
// decision value on the same multiplier (S_R1 to S_R6). An empty step goes
// from accept straight to its one result. Results leave through an output
// register that a stalling sink holds. Configuration writes are taken every cycle.
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int RADIUS_BITS = 9,
  parameter int COORD_BITS  = 12
) (
  input  logic  clk,
  input  logic  rst_n,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch,
  mer_cfg_if.sink   cfg_ch
);

  mer_cmd_t    cmd;
  mer_status_t status;
  logic        in_ready;
  logic        out_valid;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  mer_dp #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .in_center_x     (in_ch.center_x),
    .in_center_y     (in_ch.center_y),
    .in_radius_x     (in_ch.radius_x),
    .in_radius_y     (in_ch.radius_y),
    .cmd             (cmd),
    .status          (status),
    .out_pixel_x     (out_ch.pixel_x),
    .out_pixel_y     (out_ch.pixel_y),
    .out_pixel_valid (out_ch.pixel_valid),
    .out_last        (out_ch.last),
    .out_done_res    (out_ch.done_res)
  );

  // a request is worked on alone: no second accept right after one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while the previous one was still in work");

  // the output register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("pending result overwritten");

  // an empty result is always a lone, finished one
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.pixel_valid |-> out_ch.last && out_ch.done_res)
    else $error("empty result without last and done");

endmodule

`default_nettype wire

>>> rtl/core/mer_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_ctrl import mer_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_op,
  output logic        in_ready,
  input  logic        out_ready,
  output logic        out_valid,
  input  mer_status_t status,
  output mer_cmd_t    cmd
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_M1   = 14'b00000000000010,
    S_M2   = 14'b00000000000100,
    S_M3   = 14'b00000000001000,
    S_M4   = 14'b00000000010000,
    S_R1   = 14'b00000000100000,
    S_R2   = 14'b00000001000000,
    S_R3   = 14'b00000010000000,
    S_R4   = 14'b00000100000000,
    S_R5   = 14'b00001000000000,
    S_R6   = 14'b00010000000000,
    S_IT_A = 14'b00100000000000,
    S_IT_B = 14'b01000000000000,
    S_EMIT = 14'b10000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] k_r, k_nxt;
  emit_kind_t kind_r, kind_nxt;
  logic       done_r, done_nxt;
  logic       active_r, active_nxt;
  logic       region_r, region_nxt;
  logic       accept;
  logic       can_load;
  logic       emit_last;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign can_load  = !out_valid_r || out_ready;
  assign emit_last = (kind_r == EMIT_IDLE) || (k_r == K_LAST);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    kind_nxt   = kind_r;
    done_nxt   = done_r;
    active_nxt = active_r;
    region_nxt = region_r;
    cmd         = '0;
    cmd.mul_sel = MUL_RX_RX;
    cmd.wb_sel  = WB_NONE;
    cmd.region2 = region_r;
    cmd.kind    = kind_r;
    cmd.k       = k_r;
    cmd.last    = emit_last;
    cmd.done    = done_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          k_nxt = '0;
          if (in_op == OP_START) begin
            cmd.load  = 1'b1;
            state_nxt = S_M1;
          end else if (!active_r) begin
            kind_nxt  = EMIT_IDLE;
            done_nxt  = 1'b1;
            state_nxt = S_EMIT;
          end else if (!region_r && !status.grad_lt) begin
            state_nxt = S_R1;
          end else begin
            state_nxt = S_IT_A;
          end
        end
      end
      S_M1: begin
        cmd.mul_sel = MUL_RX_RX;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.mul_sel = MUL_RY_RY;
        cmd.wb_sel  = WB_RX2;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.mul_sel = MUL_RX2_RY;
        cmd.wb_sel  = WB_RY2;
        state_nxt   = S_M4;
      end
      S_M4: begin
        cmd.wb_sel = WB_START_DEC;
        done_nxt   = status.ry_zero;
        active_nxt = !status.ry_zero;
        region_nxt = 1'b0;
        kind_nxt   = EMIT_START;
        state_nxt  = S_EMIT;
      end
      // entry to region two: decision = ry2*a^2 + 4*rx2*b^2 - 4*rx2*ry2
      S_R1: begin
        cmd.mul_sel = MUL_RX2_RY2;
        state_nxt   = S_R2;
      end
      S_R2: begin
        cmd.mul_sel = MUL_A_A;
        cmd.wb_sel  = WB_DEC_INIT;
        state_nxt   = S_R3;
      end
      S_R3: begin
        cmd.mul_sel = MUL_B_B;
        cmd.wb_sel  = WB_TMP;
        state_nxt   = S_R4;
      end
      S_R4: begin
        // product uses a^2 while b^2 replaces it in the temp
        cmd.mul_sel = MUL_RY2_T;
        cmd.wb_sel  = WB_TMP;
        state_nxt   = S_R5;
      end
      S_R5: begin
        cmd.mul_sel = MUL_RX2_T;
        cmd.wb_sel  = WB_DEC_ADD;
        state_nxt   = S_R6;
      end
      S_R6: begin
        cmd.wb_sel = WB_DEC_ADD4;
        region_nxt = 1'b1;
        state_nxt  = S_IT_A;
      end
      S_IT_A: begin
        cmd.iter_a = 1'b1;
        state_nxt  = S_IT_B;
      end
      S_IT_B: begin
        cmd.iter_b = 1'b1;
        done_nxt   = status.y_zero;
        active_nxt = !status.y_zero;
        kind_nxt   = EMIT_STEP;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (can_load) begin
          cmd.out_load = 1'b1;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      kind_r      <= EMIT_IDLE;
      done_r      <= 1'b0;
      active_r    <= 1'b0;
      region_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      kind_r      <= kind_nxt;
      done_r      <= done_nxt;
      active_r    <= active_nxt;
      region_r    <= region_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mer_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_dp import mer_pkg::*; #(
  parameter int RADIUS_BITS = 9,
  parameter int COORD_BITS  = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [ORIGIN_W-1:0]          cfg_data,
  input  logic signed [CENTER_W-1:0]   in_center_x,
  input  logic signed [CENTER_W-1:0]   in_center_y,
  input  logic [RADIUS_BITS-1:0]       in_radius_x,
  input  logic [RADIUS_BITS-1:0]       in_radius_y,
  input  mer_cmd_t                     cmd,
  output mer_status_t                  status,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_pixel_valid,
  output logic                         out_last,
  output logic                         out_done_res
);

  localparam int R  = RADIUS_BITS;
  localparam int CW = COORD_BITS;
  localparam int XW = R + 2;       // point offsets
  localparam int MW = 2 * R + 6;   // multiplier operand
  localparam int PW = 2 * MW;
  localparam int GW = 3 * R + 4;   // gradients, signed
  localparam int DW = 4 * R + 6;   // decision, signed

  logic [ORIGIN_W-1:0]  org_x_r, org_y_r;
  logic [CW-1:0]        scx_r, scy_r;
  logic [R-1:0]         rx_r, ry_r;
  logic [XW-1:0]        x_r, x_nxt, y_r, y_nxt;
  logic [2*R-1:0]       rx2_r, rx2_nxt, ry2_r, ry2_nxt;
  logic signed [GW-1:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic signed [DW-1:0] dec_r, dec_nxt;
  logic [MW-1:0]        tmp_r, tmp_nxt;
  logic [PW-1:0]        prod_r;
  logic [MW-1:0]        mul_a, mul_b;

  logic [CW-1:0]        px_r, py_r;
  logic                 pv_r, last_r, done_r;

  logic [CW+ORIGIN_W-1:0] orgx_w, orgy_w;
  logic [CW+CENTER_W-1:0] cx_w, cy_w;
  logic [XW-1:0]          b_val;
  logic [MW-1:0]          rx_m, ry_m, rx2_m, ry2_m, aa_m, bb_m;
  logic signed [DW-1:0]   rx2_d, ry2_d, gx_d, gy_d, prod_s, prod_x4, delta;
  logic signed [GW-1:0]   rx2_g2, ry2_g2;
  logic                   dec_neg, dec_pos, move_x, move_y;
  logic [XW+CW-1:0]       x_w, y_w;
  logic [R+CW-1:0]        rx_w;
  logic [CW-1:0]          x_c, y_c, rx_c, dx, dy;

  // screen centre, wrapped to the coordinate width
  assign orgx_w = {{CW{1'b0}}, org_x_r};
  assign orgy_w = {{CW{1'b0}}, org_y_r};
  assign cx_w   = {{CW{in_center_x[CENTER_W-1]}}, in_center_x};
  assign cy_w   = {{CW{in_center_y[CENTER_W-1]}}, in_center_y};

  assign b_val = y_r - 1'b1;
  assign rx_m  = {{(MW-R){1'b0}}, rx_r};
  assign ry_m  = {{(MW-R){1'b0}}, ry_r};
  assign rx2_m = {{(MW-2*R){1'b0}}, rx2_r};
  assign ry2_m = {{(MW-2*R){1'b0}}, ry2_r};
  assign aa_m  = {{(MW-XW-1){1'b0}}, x_r, 1'b1};
  assign bb_m  = {{(MW-XW){1'b0}}, b_val};

  always_comb begin
    case (cmd.mul_sel)
      MUL_RX_RX: begin
        mul_a = rx_m;
        mul_b = rx_m;
      end
      MUL_RY_RY: begin
        mul_a = ry_m;
        mul_b = ry_m;
      end
      MUL_RX2_RY: begin
        mul_a = rx2_m;
        mul_b = ry_m;
      end
      MUL_RX2_RY2: begin
        mul_a = rx2_m;
        mul_b = ry2_m;
      end
      MUL_A_A: begin
        mul_a = aa_m;
        mul_b = aa_m;
      end
      MUL_B_B: begin
        mul_a = bb_m;
        mul_b = bb_m;
      end
      MUL_RY2_T: begin
        mul_a = ry2_m;
        mul_b = tmp_r;
      end
      MUL_RX2_T: begin
        mul_a = rx2_m;
        mul_b = tmp_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rx2_d   = {{(DW-2*R){1'b0}}, rx2_r};
  assign ry2_d   = {{(DW-2*R){1'b0}}, ry2_r};
  assign gx_d    = {{(DW-GW){gx_r[GW-1]}}, gx_r};
  assign gy_d    = {{(DW-GW){gy_r[GW-1]}}, gy_r};
  assign prod_s  = $signed(prod_r[DW-1:0]);
  assign prod_x4 = $signed({prod_r[DW-3:0], 2'b00});
  assign rx2_g2  = $signed({{(GW-2*R-1){1'b0}}, rx2_r, 1'b0});
  assign ry2_g2  = $signed({{(GW-2*R-1){1'b0}}, ry2_r, 1'b0});

  assign dec_neg = dec_r[DW-1];
  assign dec_pos = !dec_neg && (dec_r != '0);
  assign move_x  = !cmd.region2 || !dec_pos;
  assign move_y  = cmd.region2 || !dec_neg;

  // decision update uses the gradients already stepped in the previous cycle
  always_comb begin
    if (!cmd.region2) begin
      delta = gx_d + ry2_d - (dec_neg ? '0 : gy_d);
    end else begin
      delta = rx2_d - gy_d + (dec_pos ? '0 : gx_d);
    end
  end

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    gx_nxt  = gx_r;
    gy_nxt  = gy_r;
    dec_nxt = dec_r;
    rx2_nxt = rx2_r;
    ry2_nxt = ry2_r;
    tmp_nxt = tmp_r;
    if (cmd.load) begin
      x_nxt  = '0;
      y_nxt  = {{(XW-R){1'b0}}, in_radius_y};
      gx_nxt = '0;
    end
    if (cmd.iter_a) begin
      if (move_x) begin
        x_nxt  = x_r + 1'b1;
        gx_nxt = gx_r + ry2_g2;
      end
      if (move_y) begin
        y_nxt  = y_r - 1'b1;
        gy_nxt = gy_r - rx2_g2;
      end
    end
    if (cmd.iter_b) begin
      dec_nxt = dec_r + $signed({delta[DW-3:0], 2'b00});
    end
    case (cmd.wb_sel)
      WB_NONE: begin
      end
      WB_RX2: rx2_nxt = prod_r[2*R-1:0];
      WB_RY2: ry2_nxt = prod_r[2*R-1:0];
      WB_START_DEC: begin
        gy_nxt  = $signed({prod_r[GW-2:0], 1'b0});
        dec_nxt = $signed({ry2_d[DW-3:0], 2'b00}) - prod_x4 + rx2_d;
      end
      WB_DEC_INIT: dec_nxt = -prod_x4;
      WB_TMP:      tmp_nxt = prod_r[MW-1:0];
      WB_DEC_ADD:  dec_nxt = dec_r + prod_s;
      WB_DEC_ADD4: dec_nxt = dec_r + prod_x4;
      default: begin
      end
    endcase
  end

  assign x_w  = {{CW{1'b0}}, x_r};
  assign y_w  = {{CW{1'b0}}, y_r};
  assign rx_w = {{CW{1'b0}}, rx_r};
  assign x_c  = x_w[CW-1:0];
  assign y_c  = y_w[CW-1:0];
  assign rx_c = rx_w[CW-1:0];

  always_comb begin
    case (cmd.kind)
      EMIT_START: begin
        case (cmd.k)
          2'd0: begin
            dx = '0;
            dy = y_c;
          end
          2'd1: begin
            dx = '0;
            dy = -y_c;
          end
          2'd2: begin
            dx = rx_c;
            dy = '0;
          end
          default: begin
            dx = -rx_c;
            dy = '0;
          end
        endcase
      end
      EMIT_STEP: begin
        dx = cmd.k[1] ? -x_c : x_c;
        dy = cmd.k[0] ? -y_c : y_c;
      end
      default: begin
        dx = '0;
        dy = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= ORIGIN_RST;
      org_y_r <= ORIGIN_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ORIGIN_X) begin
        org_x_r <= cfg_data;
      end
      if (cfg_index == CFG_ORIGIN_Y) begin
        org_y_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scx_r <= orgx_w[CW-1:0] + cx_w[CW-1:0];
      scy_r <= orgy_w[CW-1:0] - cy_w[CW-1:0];
      rx_r  <= in_radius_x;
      ry_r  <= in_radius_y;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    gx_r   <= gx_nxt;
    gy_r   <= gy_nxt;
    dec_r  <= dec_nxt;
    rx2_r  <= rx2_nxt;
    ry2_r  <= ry2_nxt;
    tmp_r  <= tmp_nxt;
    prod_r <= mul_a * mul_b;
    if (cmd.out_load) begin
      if (cmd.kind == EMIT_IDLE) begin
        px_r <= '0;
        py_r <= '0;
      end else begin
        px_r <= scx_r + dx;
        py_r <= scy_r + dy;
      end
      pv_r   <= (cmd.kind != EMIT_IDLE);
      last_r <= cmd.last;
      done_r <= cmd.done;
    end
  end

  assign status.grad_lt = (gx_r < gy_r);
  assign status.y_zero  = (y_r == '0);
  assign status.ry_zero = (ry_r == '0);

  assign out_pixel_x     = $signed(px_r);
  assign out_pixel_y     = $signed(py_r);
  assign out_pixel_valid = pv_r;
  assign out_last        = last_r;
  assign out_done_res    = done_r;

endmodule

`default_nettype wire
